// ===== rtl/ctt_pkg.sv =====
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types and constants for the callout timer table.
// ----------------------------------------------------------------------------
package ctt_pkg;

    localparam int SLOTS_DEF = 8;
    localparam int MAX_FIRES = 8;
    localparam int FIRE_W    = $clog2(MAX_FIRES + 1);

    localparam int KEY_W   = 16;
    localparam int ARG_W   = 32;
    localparam int CNT_W   = 15;
    localparam int SLOT_W  = 3;

    localparam logic CMD_ARM  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_FIRE = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ARG_W-1:0] arg;
        logic [CNT_W-1:0] count;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARM_SCAN,
        ST_ARM_WR,
        ST_TICK_SCAN,
        ST_TICK_END
    } state_t;

endpackage

// ===== rtl/callout_timer_table.sv =====
// ----------------------------------------------------------------------------
// callout_timer_table
// Table of timeout slots. Arm words set, update or cancel a keyed slot;
// tick words count all armed slots down and report up to MAX_FIRES that expire.
// ----------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)                             tuser  tlast
//  s_        in   key[15:0] arg[47:16] tick_count[62:48]         cmd    -
//  m_        out  status[0] fired_key[16:1] fired_arg[48:17]     kind   last
//                 slot[51:49]
//
//  Each word walks the slots one per cycle, highest index first, unless an
//  output stall holds it; an arm scan stops early on a key match. The single
//  slot-memory read port sets the pace. s_tready is high only while idle.
//  Reset (aresetn low, synchronous) frees every slot at once. A fired result
//  is held back one step so tlast can mark the final one.
// ----------------------------------------------------------------------------
module callout_timer_table
    import ctt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key, arg, tick_count
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // status, fired_key, fired_arg, slot
    output logic        m_tuser,   // kind
    output logic        m_tlast    // last
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] TOP_IDX = IW'(SLOTS - 1);

    state_t state_reg, state_next;

    logic [IW-1:0]    idx_reg, idx_next;
    logic [KEY_W-1:0] key_reg;
    logic [ARG_W-1:0] arg_reg;
    logic [CNT_W-1:0] ticks_reg;
    logic [IW-1:0]    found_reg, found_next;
    logic             found_vld_reg, found_vld_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [FIRE_W-1:0] nfire_reg, nfire_next;

    logic             pend_vld_reg, pend_vld_next;
    logic [KEY_W-1:0] pend_key_reg, pend_key_next;
    logic [ARG_W-1:0] pend_arg_reg, pend_arg_next;
    logic [IW-1:0]    pend_idx_reg, pend_idx_next;

    logic              m_valid_reg, m_valid_next;
    logic              m_kind_reg, m_kind_next;
    logic              m_status_reg, m_status_next;
    logic [KEY_W-1:0]  m_key_reg, m_key_next;
    logic [ARG_W-1:0]  m_arg_reg, m_arg_next;
    logic [SLOT_W-1:0] m_slot_reg, m_slot_next;
    logic              m_last_reg, m_last_next;

    logic   wr_en;
    logic [IW-1:0] wr_addr;
    entry_t wr_data;
    entry_t rd_data;

    logic accept, out_free, last_idx;
    logic cur_valid, hit, fire, skip_zero, stall;
    logic [IW+SLOT_W-1:0] pend_ext, found_ext;

    ctt_slot_mem #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_next),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign last_idx = (idx_reg == '0);

    assign cur_valid = valid_reg[idx_reg];
    assign hit       = cur_valid && (rd_data.key == key_reg);
    assign fire      = cur_valid && (rd_data.count == '0) &&
                       (nfire_reg < FIRE_W'(MAX_FIRES));
    assign skip_zero = cur_valid && (rd_data.count == '0) && !fire;
    assign stall     = fire && pend_vld_reg && !out_free;

    assign pend_ext  = {{SLOT_W{1'b0}}, pend_idx_reg};
    assign found_ext = {{SLOT_W{1'b0}}, found_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_tuser == CMD_TICK) ? ST_TICK_SCAN : ST_ARM_SCAN;
                end
            end
            ST_ARM_SCAN: begin
                if (hit || last_idx) begin
                    state_next = ST_ARM_WR;
                end
            end
            ST_ARM_WR: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_TICK_SCAN: begin
                if (!stall && last_idx) begin
                    state_next = ST_TICK_END;
                end
            end
            ST_TICK_END: begin
                if (!pend_vld_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        idx_next       = idx_reg;
        found_next     = found_reg;
        found_vld_next = found_vld_reg;
        valid_next     = valid_reg;
        nfire_next     = nfire_reg;
        pend_vld_next  = pend_vld_reg;
        pend_key_next  = pend_key_reg;
        pend_arg_next  = pend_arg_reg;
        pend_idx_next  = pend_idx_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_kind_next    = m_kind_reg;
        m_status_next  = m_status_reg;
        m_key_next     = m_key_reg;
        m_arg_next     = m_arg_reg;
        m_slot_next    = m_slot_reg;
        m_last_next    = m_last_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = rd_data;

        case (state_reg)
            ST_IDLE: begin
                idx_next       = TOP_IDX;
                found_vld_next = 1'b0;
                nfire_next     = '0;
            end
            ST_ARM_SCAN: begin
                if (hit) begin
                    found_next     = idx_reg;
                    found_vld_next = 1'b1;
                end else begin
                    if (!cur_valid && !found_vld_reg) begin
                        found_next     = idx_reg;
                        found_vld_next = 1'b1;
                    end
                    if (!last_idx) begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            ST_ARM_WR: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = KIND_ACK;
                    m_key_next    = '0;
                    m_arg_next    = '0;
                    m_last_next   = 1'b1;
                    if (found_vld_reg) begin
                        wr_en         = 1'b1;
                        wr_addr       = found_reg;
                        wr_data.key   = (ticks_reg != '0) ? key_reg : '0;
                        wr_data.arg   = arg_reg;
                        wr_data.count = ticks_reg;
                        valid_next[found_reg] = (ticks_reg != '0);
                        m_status_next = STATUS_OK;
                        m_slot_next   = found_ext[SLOT_W-1:0];
                    end else begin
                        m_status_next = STATUS_FULL;
                        m_slot_next   = '0;
                    end
                    idx_next = TOP_IDX;
                end
            end
            ST_TICK_SCAN: begin
                if (!stall) begin
                    if (fire) begin
                        if (pend_vld_reg) begin
                            m_valid_next  = 1'b1;
                            m_kind_next   = KIND_FIRE;
                            m_status_next = STATUS_OK;
                            m_key_next    = pend_key_reg;
                            m_arg_next    = pend_arg_reg;
                            m_slot_next   = pend_ext[SLOT_W-1:0];
                            m_last_next   = 1'b0;
                        end
                        pend_vld_next       = 1'b1;
                        pend_key_next       = rd_data.key;
                        pend_arg_next       = rd_data.arg;
                        pend_idx_next       = idx_reg;
                        valid_next[idx_reg] = 1'b0;
                        nfire_next          = nfire_reg + 1'b1;
                    end else if (cur_valid && !skip_zero) begin
                        wr_en         = 1'b1;
                        wr_data.count = rd_data.count - 1'b1;
                    end
                    idx_next = last_idx ? TOP_IDX : idx_reg - 1'b1;
                end
            end
            ST_TICK_END: begin
                idx_next = TOP_IDX;
                if (pend_vld_reg && out_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = KIND_FIRE;
                    m_status_next = STATUS_OK;
                    m_key_next    = pend_key_reg;
                    m_arg_next    = pend_arg_reg;
                    m_slot_next   = pend_ext[SLOT_W-1:0];
                    m_last_next   = 1'b1;
                    pend_vld_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= TOP_IDX;
            found_vld_reg <= 1'b0;
            valid_reg     <= '0;
            nfire_reg     <= '0;
            pend_vld_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            found_vld_reg <= found_vld_next;
            valid_reg     <= valid_next;
            nfire_reg     <= nfire_next;
            pend_vld_reg  <= pend_vld_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            key_reg   <= s_tdata[15:0];
            arg_reg   <= s_tdata[47:16];
            ticks_reg <= s_tdata[62:48];
        end
        found_reg    <= found_next;
        pend_key_reg <= pend_key_next;
        pend_arg_reg <= pend_arg_next;
        pend_idx_reg <= pend_idx_next;
        m_kind_reg   <= m_kind_next;
        m_status_reg <= m_status_next;
        m_key_reg    <= m_key_next;
        m_arg_reg    <= m_arg_next;
        m_slot_reg   <= m_slot_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {4'b0000, m_slot_reg, m_arg_reg, m_key_reg, m_status_reg};

endmodule

// ===== rtl/ctt_slot_mem.sv =====
// ----------------------------------------------------------------------------
// ctt_slot_mem
// Slot payload storage: key, argument and count per slot, one write port,
// one read port with registered read data.
// ----------------------------------------------------------------------------
module ctt_slot_mem
    import ctt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic [IW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [SLOTS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule
